// ===== hw/rtl/tfot_pkg.sv =====
// Package for the timed and flashing output table: codes, item types and defaults.
`default_nettype none
package tfot_pkg;

  localparam int TABLE_ENTRIES_DEF = 24;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PLAIN   = 3'd1;
  localparam logic [2:0] OP_TIMED   = 3'd2;
  localparam logic [2:0] OP_FLASH   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_SERVICE = 3'd5;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_HIGH   = 2'd1;
  localparam logic [1:0] ACT_LOW    = 2'd2;
  localparam logic [1:0] ACT_TOGGLE = 2'd3;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_TIMED = 2'd1;
  localparam logic [1:0] KIND_FLASH = 2'd2;

  localparam int ENTRY_W = 50;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] output_id;
    logic [15:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] action_output;
    logic        table_full;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [15:0] period;
    logic [15:0] remain;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/timed_flash_output_table.sv =====
// An item is accepted in S_IDLE; S_SCAN then fetches the first entry and walks the occupied
// entries at one per cycle, but stalls while a service pass waits for the output; each entry
// removed from the middle takes an S_MOVE step, and after the end S_DONE delivers the result.
// Only one item is taken at a time: in_ready is high only in S_IDLE.
// Reset: synchronous, active low; clears the fill count and all control state. RAM contents
// are not cleared: entries at or above the fill count are never read, so no clearing pass.
`default_nettype none
module timed_flash_output_table
  import tfot_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic        vld_r, vld_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [1:0]  pend_act_r, pend_act_nxt;
  logic [15:0] pend_id_r, pend_id_nxt;
  logic [1:0]  fin_act_r, fin_act_nxt;
  logic        fin_full_r, fin_full_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  entry_t        ent, new_ent;
  logic          can_emit;
  logic          advance;
  logic          start_remove;
  logic [CW-1:0] ptr_inc, top;

  tfot_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent       = entry_t'(ram_rdata);
  assign can_emit  = !out_valid_r || out_ready;
  assign ptr_inc   = ptr_r + CW'(1);
  assign top       = count_r - CW'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    new_ent.kind   = (op_r == OP_TIMED) ? KIND_TIMED : KIND_FLASH;
    new_ent.id     = id_r;
    new_ent.period = dur_r;
    new_ent.remain = dur_r;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    vld_nxt       = vld_r;
    pend_vld_nxt  = pend_vld_r;
    pend_act_nxt  = pend_act_r;
    pend_id_nxt   = pend_id_r;
    fin_act_nxt   = fin_act_r;
    fin_full_nxt  = fin_full_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    dur_nxt       = dur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r[IW-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r[IW-1:0];
    advance       = 1'b0;
    start_remove  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.op;
          id_nxt       = in_data.output_id;
          dur_nxt      = in_data.duration;
          ptr_nxt      = '0;
          vld_nxt      = 1'b0;
          pend_vld_nxt = 1'b0;
          fin_full_nxt = 1'b0;
          unique case (in_data.op) inside
            OP_TICK: begin
              fin_act_nxt = ACT_NONE;
              state_nxt   = S_SCAN;
            end
            OP_PLAIN: begin
              fin_act_nxt = ACT_HIGH;
              state_nxt   = S_DONE;
            end
            OP_TIMED, OP_FLASH: begin
              fin_act_nxt = ACT_HIGH;
              state_nxt   = (in_data.duration != 16'd0) ? S_SCAN : S_DONE;
            end
            OP_CLEAR: begin
              fin_act_nxt = ACT_LOW;
              state_nxt   = S_SCAN;
            end
            OP_SERVICE: begin
              fin_act_nxt = ACT_NONE;
              state_nxt   = S_SCAN;
            end
            default: begin
              fin_act_nxt = ACT_NONE;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!vld_r) begin
          if (ptr_r < count_r) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r[IW-1:0];
            vld_nxt   = 1'b1;
          end else begin
            // end of occupied run: a set that found no match takes the first free slot, or flags the table full
            if (op_r == OP_TIMED || op_r == OP_FLASH) begin
              if (count_r < CW'(TABLE_ENTRIES)) begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IW-1:0];
                ram_wdata = new_ent;
                count_nxt = count_r + CW'(1);
              end else begin
                fin_full_nxt = 1'b1;
              end
            end
            state_nxt = S_DONE;
          end
        end else begin
          case (op_r) inside
            OP_TICK: begin
              if (ent.remain != 16'd0) begin
                ram_we    = 1'b1;
                ram_wdata = {ent.kind, ent.id, ent.period, ent.remain - 16'd1};
              end
              advance = 1'b1;
            end
            OP_TIMED, OP_FLASH: begin
              if (ent.id == id_r) begin
                ram_we    = 1'b1;
                ram_wdata = new_ent;
                vld_nxt   = 1'b0;
                state_nxt = S_DONE;
              end else begin
                advance = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (ent.id == id_r) begin
                start_remove = 1'b1;
              end else begin
                advance = 1'b1;
              end
            end
            OP_SERVICE: begin
              if (ent.remain == 16'd0 &&
                  (ent.kind == KIND_TIMED || ent.kind == KIND_FLASH)) begin
                // hold until the staged result can move to the output
                if (!pend_vld_r || can_emit) begin
                  if (pend_vld_r) begin
                    out_valid_nxt = 1'b1;
                    out_nxt       = '{pend_act_r, pend_id_r, 1'b0, 1'b0};
                  end
                  pend_vld_nxt = 1'b1;
                  pend_id_nxt  = ent.id;
                  if (ent.kind == KIND_FLASH) begin
                    pend_act_nxt = ACT_TOGGLE;
                    ram_we       = 1'b1;
                    ram_wdata    = {ent.kind, ent.id, ent.period, ent.period};
                    advance      = 1'b1;
                  end else begin
                    pend_act_nxt = ACT_LOW;
                    start_remove = 1'b1;
                  end
                end
              end else begin
                advance = 1'b1;
              end
            end
            default: begin
              vld_nxt   = 1'b0;
              state_nxt = S_DONE;
            end
          endcase

          if (advance) begin
            ptr_nxt = ptr_inc;
            if (ptr_inc < count_r) begin
              ram_re    = 1'b1;
              ram_raddr = ptr_inc[IW-1:0];
            end else begin
              vld_nxt = 1'b0;
            end
          end

          if (start_remove) begin
            vld_nxt = 1'b0;
            if (ptr_r == top) begin
              // hole is the last entry: nothing to move, and nothing left to visit
              count_nxt = top;
              state_nxt = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top[IW-1:0];
              state_nxt = S_MOVE;
            end
          end
        end
      end

      S_MOVE: begin
        // fill the hole with the last entry; the moved entry is skipped
        ram_we    = 1'b1;
        ram_waddr = ptr_r[IW-1:0];
        ram_wdata = ram_rdata;
        count_nxt = top;
        vld_nxt   = 1'b0;
        if (op_r == OP_CLEAR) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SCAN;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = '{pend_act_r, pend_id_r, 1'b0, 1'b1};
          end else begin
            out_nxt = '{fin_act_r, (fin_act_r == ACT_NONE) ? 16'd0 : id_r, fin_full_r, 1'b1};
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      vld_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      vld_r       <= vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_act_r <= pend_act_nxt;
    pend_id_r  <= pend_id_nxt;
    fin_act_r  <= fin_act_nxt;
    fin_full_r <= fin_full_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    dur_r      <= dur_nxt;
    out_r      <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("fill count exceeds table depth");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("read and write of the same entry in one cycle");

  a_pend_service: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (op_r == OP_SERVICE && state_r != S_IDLE))
    else $error("staged result outside a service pass");

  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("entry move did not shrink the table");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/tfot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tfot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
